>>> src/polynomial_store_horner_eval_macros.svh
// assertion macros used by the top-level rtl
// each checks on the rising edge of i_clk, ignored while i_rst_n is low
`ifndef POLYNOMIAL_STORE_HORNER_EVAL_MACROS_SVH
`define POLYNOMIAL_STORE_HORNER_EVAL_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define PHE_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define PHE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define PHE_ASSERT_IMPLIES(lbl, ante, cons)
`define PHE_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

>>> src/phe_pkg.sv
`timescale 1ns / 1ps

package phe_pkg;

    localparam int MAX_TERMS_DEF = 16;
    localparam int FRAC_BITS_DEF = 16;

    localparam int ACTION_W = 2;
    localparam int COEF_W   = 32;
    localparam int POWER_W  = 4;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int TCOUNT_W = 5;
    localparam int PROD_W   = 2 * COEF_W;

    localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

    typedef enum logic [ACTION_W-1:0] {
        ACT_APPEND = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_EVAL   = 2'd3
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_ABSENT = 2'd1,
        ST_FULL   = 2'd2,
        ST_EMPTY  = 2'd3
    } t_status;

    // coefficient store write source
    typedef enum logic [2:0] {
        WR_NONE   = 3'd0,
        WR_APPEND = 3'd1,
        WR_ZERO   = 3'd2,
        WR_SHIFT  = 3'd3,
        WR_CONST  = 3'd4
    } t_wsel;

    // coefficient store read address
    typedef enum logic [1:0] {
        RD_NONE  = 2'd0,
        RD_TOP   = 2'd1,
        RD_PTRM1 = 2'd2
    } t_rsel;

    typedef struct packed {
        logic    capture;
        t_wsel   wr_sel;
        t_rsel   rd_sel;
        logic    ptr_init_cnt;
        logic    ptr_init_top;
        logic    ptr_dec;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    acc_load;
        logic    prod_load;
        logic    rnd_load;
        logic    acc_step;
        logic    res_load;
        t_status res_status;
        logic    res_value;
    } t_cmd;

    typedef struct packed {
        t_action action;
        logic    full;
        logic    empty;
        logic    absent;
        logic    top;
        logic    ptr_one;
        logic    ptr_zero;
        logic    out_free;
    } t_flags;

endpackage

>>> src/phe_req_if.sv
`timescale 1ns / 1ps

interface phe_req_if;
    logic                                valid;
    logic                                ready;
    logic        [phe_pkg::ACTION_W-1:0] action;
    logic signed [phe_pkg::COEF_W-1:0]   coef;
    logic        [phe_pkg::POWER_W-1:0]  power;
    logic signed [phe_pkg::COEF_W-1:0]   x_value;

    modport source (output valid, action, coef, power, x_value, input ready);
    modport sink   (input valid, action, coef, power, x_value, output ready);
endinterface

>>> src/phe_rsp_if.sv
`timescale 1ns / 1ps

interface phe_rsp_if;
    logic                                valid;
    logic                                ready;
    logic signed [phe_pkg::VALUE_W-1:0]  value;
    logic        [phe_pkg::STATUS_W-1:0] status;
    logic        [phe_pkg::TCOUNT_W-1:0] term_count;

    modport source (output valid, value, status, term_count, input ready);
    modport sink   (input valid, value, status, term_count, output ready);
endinterface

>>> src/phe_ram.sv
`timescale 1ns / 1ps

module phe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/phe_ctrl.sv
`timescale 1ns / 1ps

module phe_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  phe_pkg::t_flags i_flags,
    output phe_pkg::t_cmd   o_cmd
);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_DECODE = 10'b0000000010,
        S_SH_RD  = 10'b0000000100,
        S_SH_WR  = 10'b0000001000,
        S_SH_END = 10'b0000010000,
        S_E_LOAD = 10'b0000100000,
        S_E_MUL  = 10'b0001000000,
        S_E_RND  = 10'b0010000000,
        S_E_ADD  = 10'b0100000000,
        S_DONE   = 10'b1000000000
    } t_state;

    t_state           r_state, n_state;
    phe_pkg::t_status r_st, n_st;
    logic             r_val, n_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_st    <= phe_pkg::ST_OK;
            r_val   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_st    <= n_st;
            r_val   <= n_val;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_st       = r_st;
        n_val      = r_val;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_DONE;
                n_st    = phe_pkg::ST_OK;
                n_val   = 1'b0;
                case (i_flags.action)
                    phe_pkg::ACT_APPEND: begin
                        if (i_flags.full) begin
                            n_st = phe_pkg::ST_FULL;
                        end else begin
                            o_cmd.wr_sel  = phe_pkg::WR_APPEND;
                            o_cmd.cnt_inc = 1'b1;
                        end
                    end
                    phe_pkg::ACT_INSERT: begin
                        if (i_flags.full) begin
                            n_st = phe_pkg::ST_FULL;
                        end else if (i_flags.empty) begin
                            o_cmd.wr_sel  = phe_pkg::WR_CONST;
                            o_cmd.cnt_inc = 1'b1;
                        end else begin
                            o_cmd.ptr_init_cnt = 1'b1;
                            n_state            = S_SH_RD;
                        end
                    end
                    phe_pkg::ACT_REMOVE: begin
                        if (i_flags.empty) begin
                            n_st = phe_pkg::ST_EMPTY;
                        end else if (i_flags.absent) begin
                            n_st = phe_pkg::ST_ABSENT;
                        end else if (i_flags.top) begin
                            o_cmd.cnt_dec = 1'b1;
                        end else begin
                            o_cmd.wr_sel = phe_pkg::WR_ZERO;
                        end
                    end
                    phe_pkg::ACT_EVAL: begin
                        if (i_flags.empty) begin
                            n_st = phe_pkg::ST_EMPTY;
                        end else begin
                            o_cmd.rd_sel       = phe_pkg::RD_TOP;
                            o_cmd.ptr_init_top = 1'b1;
                            n_val              = 1'b1;
                            n_state            = S_E_LOAD;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_SH_RD: begin
                o_cmd.rd_sel = phe_pkg::RD_PTRM1;
                n_state      = S_SH_WR;
            end
            S_SH_WR: begin
                o_cmd.wr_sel  = phe_pkg::WR_SHIFT;
                o_cmd.ptr_dec = 1'b1;
                n_state       = i_flags.ptr_one ? S_SH_END : S_SH_RD;
            end
            S_SH_END: begin
                o_cmd.wr_sel  = phe_pkg::WR_CONST;
                o_cmd.cnt_inc = 1'b1;
                n_state       = S_DONE;
            end
            S_E_LOAD: begin
                o_cmd.acc_load = 1'b1;
                if (i_flags.ptr_zero) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.rd_sel  = phe_pkg::RD_PTRM1;
                    o_cmd.ptr_dec = 1'b1;
                    n_state       = S_E_MUL;
                end
            end
            S_E_MUL: begin
                o_cmd.prod_load = 1'b1;
                n_state         = S_E_RND;
            end
            S_E_RND: begin
                o_cmd.rnd_load = 1'b1;
                n_state        = S_E_ADD;
            end
            S_E_ADD: begin
                o_cmd.acc_step = 1'b1;
                if (i_flags.ptr_zero) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.rd_sel  = phe_pkg::RD_PTRM1;
                    o_cmd.ptr_dec = 1'b1;
                    n_state       = S_E_MUL;
                end
            end
            S_DONE: begin
                o_cmd.res_status = r_st;
                o_cmd.res_value  = r_val;
                if (i_flags.out_free) begin
                    o_cmd.res_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> src/phe_dp.sv
`timescale 1ns / 1ps

module phe_dp #(
    parameter int MAX_TERMS = phe_pkg::MAX_TERMS_DEF,
    parameter int FRAC_BITS = phe_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic        [phe_pkg::ACTION_W-1:0] i_action,
    input  logic signed [phe_pkg::COEF_W-1:0]   i_coef,
    input  logic        [phe_pkg::POWER_W-1:0]  i_power,
    input  logic signed [phe_pkg::COEF_W-1:0]   i_x_value,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic signed [phe_pkg::VALUE_W-1:0]  o_value,
    output logic        [phe_pkg::STATUS_W-1:0] o_status,
    output logic        [phe_pkg::TCOUNT_W-1:0] o_term_count,
    input  phe_pkg::t_cmd                       i_cmd,
    output phe_pkg::t_flags                     o_flags
);

    localparam int AW     = $clog2(MAX_TERMS);
    localparam int CW     = $clog2(MAX_TERMS + 1);
    localparam int EW     = CW + phe_pkg::POWER_W;
    localparam int TW     = CW + phe_pkg::TCOUNT_W;
    localparam int PW     = phe_pkg::PROD_W;
    localparam int SW     = PW + 1;
    localparam logic signed [PW-1:0] HALF = (PW'(1) << FRAC_BITS) >> 1;

    phe_pkg::t_action            r_action;
    logic signed [phe_pkg::COEF_W-1:0] r_coef;
    logic [phe_pkg::POWER_W-1:0] r_power;
    logic signed [phe_pkg::COEF_W-1:0] r_x;
    logic [CW-1:0]               r_count;
    logic [CW-1:0]               r_ptr;
    logic signed [phe_pkg::COEF_W-1:0] r_acc;
    logic signed [PW-1:0]        r_prod;
    logic signed [PW-1:0]        r_rnd;
    logic                        r_out_valid;
    logic signed [phe_pkg::VALUE_W-1:0] r_value;
    logic [phe_pkg::STATUS_W-1:0] r_status;
    logic [phe_pkg::TCOUNT_W-1:0] r_tcount;

    logic [EW-1:0]               power_ext;
    logic [EW-1:0]               count_ext;
    logic [TW-1:0]               count_wide;
    logic [CW-1:0]               count_m1;
    logic [CW-1:0]               ptr_m1;
    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [phe_pkg::COEF_W-1:0]  ram_wdata;
    logic                        ram_re;
    logic [AW-1:0]               ram_raddr;
    logic [phe_pkg::COEF_W-1:0]  ram_rdata;
    logic signed [phe_pkg::COEF_W-1:0] rdata_s;
    logic signed [PW-1:0]        n_prod;
    logic signed [PW-1:0]        n_rnd;
    logic signed [SW-1:0]        sum;
    logic signed [phe_pkg::COEF_W-1:0] n_acc_sat;

    assign power_ext  = EW'(r_power);
    assign count_ext  = EW'(r_count);
    assign count_wide = TW'(r_count);
    assign count_m1   = r_count - CW'(1);
    assign ptr_m1     = r_ptr - CW'(1);
    assign rdata_s    = $signed(ram_rdata);

    always_comb begin
        o_flags          = '0;
        o_flags.action   = r_action;
        o_flags.full     = (r_count == CW'(MAX_TERMS));
        o_flags.empty    = (r_count == '0);
        o_flags.absent   = (power_ext >= count_ext);
        o_flags.top      = (power_ext == (count_ext - EW'(1)));
        o_flags.ptr_one  = (r_ptr == CW'(1));
        o_flags.ptr_zero = (r_ptr == '0);
        o_flags.out_free = !r_out_valid || i_out_ready;
    end

    // store port selection
    always_comb begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = r_coef;
        case (i_cmd.wr_sel)
            phe_pkg::WR_APPEND: ram_waddr = r_count[AW-1:0];
            phe_pkg::WR_ZERO: begin
                ram_waddr = power_ext[AW-1:0];
                ram_wdata = '0;
            end
            phe_pkg::WR_SHIFT: begin
                ram_waddr = r_ptr[AW-1:0];
                ram_wdata = ram_rdata;
            end
            phe_pkg::WR_CONST: ram_waddr = '0;
            default: ram_we = 1'b0;
        endcase
    end

    always_comb begin
        ram_re    = 1'b1;
        ram_raddr = '0;
        case (i_cmd.rd_sel)
            phe_pkg::RD_TOP:   ram_raddr = count_m1[AW-1:0];
            phe_pkg::RD_PTRM1: ram_raddr = ptr_m1[AW-1:0];
            default:           ram_re    = 1'b0;
        endcase
    end

    phe_ram #(
        .WIDTH (phe_pkg::COEF_W),
        .DEPTH (MAX_TERMS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // horner step: multiply, round, add and saturate
    assign n_prod = PW'(r_acc) * PW'(r_x);
    assign n_rnd  = (r_prod + HALF) >>> FRAC_BITS;
    assign sum    = SW'(r_rnd) + SW'(rdata_s);

    always_comb begin
        if (sum > SW'(phe_pkg::COEF_MAX)) begin
            n_acc_sat = phe_pkg::COEF_MAX;
        end else if (sum < SW'(phe_pkg::COEF_MIN)) begin
            n_acc_sat = phe_pkg::COEF_MIN;
        end else begin
            n_acc_sat = sum[phe_pkg::COEF_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.cnt_inc) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.cnt_dec) begin
                r_count <= count_m1;
            end
            if (i_cmd.res_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action <= phe_pkg::t_action'(i_action);
            r_coef   <= i_coef;
            r_power  <= i_power;
            r_x      <= i_x_value;
        end
        if (i_cmd.ptr_init_cnt) begin
            r_ptr <= r_count;
        end else if (i_cmd.ptr_init_top) begin
            r_ptr <= count_m1;
        end else if (i_cmd.ptr_dec) begin
            r_ptr <= ptr_m1;
        end
        if (i_cmd.acc_load) begin
            r_acc <= rdata_s;
        end else if (i_cmd.acc_step) begin
            r_acc <= n_acc_sat;
        end
        if (i_cmd.prod_load) begin
            r_prod <= n_prod;
        end
        if (i_cmd.rnd_load) begin
            r_rnd <= n_rnd;
        end
        if (i_cmd.res_load) begin
            r_value  <= i_cmd.res_value ? r_acc : '0;
            r_status <= i_cmd.res_status;
            r_tcount <= count_wide[phe_pkg::TCOUNT_W-1:0];
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_value      = r_value;
    assign o_status     = r_status;
    assign o_term_count = r_tcount;

endmodule

>>> src/polynomial_store_horner_eval.sv
// Polynomial store with Horner evaluation. Holds up to MAX_TERMS signed fixed-point
// coefficients (FRAC_BITS fractional bits, Q16.16 by default) indexed by power, and
// takes one request at a time: append a coefficient as the next higher power,
// insert a new constant term (every held term moves up one power), remove a power
// (a lower power is zeroed, the top power is dropped), or evaluate at x by Horner's
// rule with round-to-nearest scaling and saturation after every step. Each request
// gives one response with the value (zero unless a successful evaluate), a status
// (ok, power not present, table full, table empty) and the term count afterwards.
// Insert with terms already held moves each coefficient up in turn, since the store,
// with its registered read, moves one coefficient every read/write pair; evaluate
// runs a multiply, round and add-with-saturate loop through the accumulator. A new
// request is taken once the previous one is finished, while its response may still
// wait in the output register. No clearing pass after reset.
`timescale 1ns / 1ps
`include "polynomial_store_horner_eval_macros.svh"

module polynomial_store_horner_eval #(
    parameter int MAX_TERMS = phe_pkg::MAX_TERMS_DEF,
    parameter int FRAC_BITS = phe_pkg::FRAC_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    phe_req_if.sink         i_req,
    phe_rsp_if.source       o_rsp
);

    // command and status between sequencer and datapath
    phe_pkg::t_cmd   cmd;
    phe_pkg::t_flags flags;
    logic            in_ready;

    // sequencer: decode, shift loop, horner loop, response hand-off
    phe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (in_ready),
        .i_flags    (flags),
        .o_cmd      (cmd)
    );

    // datapath: request capture, coefficient store, term count, mac, response register
    phe_dp #(
        .MAX_TERMS (MAX_TERMS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_action     (i_req.action),
        .i_coef       (i_req.coef),
        .i_power      (i_req.power),
        .i_x_value    (i_req.x_value),
        .i_out_ready  (o_rsp.ready),
        .o_out_valid  (o_rsp.valid),
        .o_value      (o_rsp.value),
        .o_status     (o_rsp.status),
        .o_term_count (o_rsp.term_count),
        .i_cmd        (cmd),
        .o_flags      (flags)
    );

    assign i_req.ready = in_ready;

    // one request in flight: no new request the cycle after one is taken
    `PHE_ASSERT_NEXT(a_one_in_flight, i_req.valid && i_req.ready, !i_req.ready)

    // the term count never grows past a full table
    `PHE_ASSERT_IMPLIES(a_no_overfill, cmd.cnt_inc, !flags.full)

    // a finished response never overwrites one still waiting
    `PHE_ASSERT_IMPLIES(a_no_overwrite, cmd.res_load, flags.out_free)

    // a nonzero value only comes with an ok status
    `PHE_ASSERT_IMPLIES(a_value_ok, o_rsp.valid && (o_rsp.value != '0),
                        o_rsp.status == phe_pkg::ST_OK)

endmodule
